>>> rtl/urth_pkg.sv
`default_nettype none

package urth_pkg;

    localparam int COUNT_W = 6;
    localparam int KIND_W  = 2;
    localparam int WORD_W  = 32;

    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_UNDO   = 2'd1;
    localparam logic [1:0] CMD_REDO   = 2'd2;
    localparam logic [1:0] CMD_WIPE   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_UNMARKED = 2'd0;

    // one history entry as it sits in the ring memory
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] id;
        logic [WORD_W-1:0] old_val;
        logic [WORD_W-1:0] new_val;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // kinds 2 and 3 open a new instruction group
    function automatic logic is_group(input logic [KIND_W-1:0] kind);
        return kind[KIND_W-1];
    endfunction

endpackage

`default_nettype wire

>>> rtl/urth_ram.sv
`default_nettype none

module urth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while the read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/undo_redo_trace_history.sv
// undo/redo trace history ring buffer
// record and wipe requests produce no result; an undo/redo run of n records reads
// through the ring memory read stage into the output register, one result per cycle
// (one ring memory read per cycle) unless the receiver stalls, n+1 results at most
// a new request is taken once the previous run has left the read stage
// synchronous active-low reset clears pointers, recording enable and valids
`default_nettype none

module undo_redo_trace_history
    import urth_pkg::*;
#(
    parameter int DEPTH_LOG2 = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [1:0]          i_command,
    input  wire logic [KIND_W-1:0]   i_change_kind,
    input  wire logic signed [31:0]  i_target_id,
    input  wire logic [WORD_W-1:0]   i_old_value,
    input  wire logic [WORD_W-1:0]   i_new_value,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_has_value,
    output logic signed [31:0]       o_restore_id,
    output logic [WORD_W-1:0]        o_restore_value,
    output logic                     o_last,
    output logic                     o_end_reached,
    output logic [COUNT_W-1:0]       o_entry_count
);

    localparam int DEPTH = 1 << DEPTH_LOG2;
    localparam logic [DEPTH_LOG2-1:0] PTR_FULL = DEPTH_LOG2'(DEPTH - 1);

    logic                  r_rec_en;
    logic [DEPTH_LOG2-1:0] r_head, r_tail, r_cursor;
    logic                  r_run, r_undo;
    logic                  r_b_vld, r_b_bnd;
    logic                  r_out_vld;
    logic                  r_out_has, r_out_last, r_out_end;
    logic [WORD_W-1:0]     r_out_id, r_out_val;
    logic [COUNT_W-1:0]    r_out_cnt;

    logic                  n_run, n_b_vld, n_b_bnd, n_out_vld;
    logic [DEPTH_LOG2-1:0] n_head, n_tail, n_cursor;

    logic                  in_acc, do_rec, out_ready, adv_b, b_grp;
    logic                  issue, at_end;
    logic [DEPTH_LOG2-1:0] rd_addr, cnt_now, cnt_rec;
    t_rec                  wr_rec, rd_rec;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_run || r_b_vld;

    assign do_rec = in_acc && (i_command == CMD_RECORD) && r_rec_en &&
                    ((i_old_value != i_new_value) || (i_change_kind != KIND_UNMARKED));

    assign wr_rec.kind    = i_change_kind;
    assign wr_rec.id      = i_target_id;
    assign wr_rec.old_val = i_old_value;
    assign wr_rec.new_val = i_new_value;

    assign out_ready = !r_out_vld || !i_out_stall;
    assign adv_b     = !r_b_vld || out_ready;
    assign b_grp     = r_b_vld && !r_b_bnd && is_group(rd_rec.kind);

    // issue the next read; stop as soon as a group record shows up in the read stage
    assign issue   = r_run && adv_b && !b_grp;
    assign at_end  = r_undo ? (r_cursor == r_tail) : (r_cursor == r_head);
    assign rd_addr = r_undo ? (r_cursor - 1'b1) : r_cursor;

    assign cnt_now = r_head - r_tail;
    assign cnt_rec = r_cursor - r_tail;

    urth_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (do_rec),
        .i_waddr (r_cursor),
        .i_wdata (wr_rec),
        .i_re    (issue && !at_end),
        .i_raddr (rd_addr),
        .o_rdata (rd_rec)
    );

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_cursor = r_cursor;
        n_run    = r_run;
        n_b_vld  = r_b_vld;
        n_b_bnd  = r_b_bnd;
        n_out_vld = r_out_vld;

        if (in_acc) begin
            unique case (i_command)
                CMD_RECORD: begin
                    if (do_rec) begin
                        // redo history past the cursor is dropped
                        if (cnt_rec == PTR_FULL) begin
                            n_tail = r_tail + 1'b1;
                        end
                        n_head   = r_cursor + 1'b1;
                        n_cursor = r_cursor + 1'b1;
                    end
                end
                CMD_UNDO, CMD_REDO: begin
                    n_run = 1'b1;
                end
                CMD_WIPE: begin
                    n_head   = '0;
                    n_tail   = '0;
                    n_cursor = '0;
                end
                default: begin
                    n_run = r_run;
                end
            endcase
        end

        if (issue) begin
            if (at_end) begin
                n_run = 1'b0;
            end else if (r_undo) begin
                n_cursor = r_cursor - 1'b1;
            end else begin
                n_cursor = r_cursor + 1'b1;
            end
        end

        if (adv_b) begin
            n_b_vld = issue;
            n_b_bnd = at_end;
            if (b_grp) begin
                n_run = 1'b0;
            end
        end

        if (out_ready) begin
            n_out_vld = r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_en  <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
            r_cursor  <= '0;
            r_run     <= 1'b0;
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rec_en <= i_cfg_wdata;
            end
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_cursor  <= n_cursor;
            r_run     <= n_run;
            r_b_vld   <= n_b_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_bnd <= n_b_bnd;
        if (in_acc) begin
            r_undo <= (i_command == CMD_UNDO);
        end
        if (out_ready && r_b_vld) begin
            r_out_has  <= !r_b_bnd;
            r_out_id   <= r_b_bnd ? '0 : rd_rec.id;
            r_out_val  <= r_b_bnd ? '0 : (r_undo ? rd_rec.old_val : rd_rec.new_val);
            r_out_last <= r_b_bnd || b_grp;
            r_out_end  <= r_b_bnd;
            r_out_cnt  <= COUNT_W'(cnt_now);
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_has_value     = r_out_has;
    assign o_restore_id    = r_out_id;
    assign o_restore_value = r_out_val;
    assign o_last          = r_out_last;
    assign o_end_reached   = r_out_end;
    assign o_entry_count   = r_out_cnt;

endmodule

`default_nettype wire

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import urth_pkg::*;

    localparam int DEPTH_LOG2  = 6;
    localparam int DEPTH       = 1 << DEPTH_LOG2;
    localparam int HALF_PERIOD = 6;
    localparam int SETTLE      = 8;
    localparam int HOLD_AT     = 40;
    localparam int HOLD_LEN    = 150;
    localparam int QUIET_LIMIT = 1000;

    localparam logic [KIND_W-1:0] KIND_OPCODE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GROUP     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_GROUP_ALT = 2'd3;

    typedef bit [DEPTH_LOG2-1:0] t_ptr;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [KIND_W-1:0] kind;
        logic [31:0]       id;
        logic [WORD_W-1:0] old_val;
        logic [WORD_W-1:0] new_val;
    } t_request;

    typedef struct packed {
        logic               has_value;
        logic [31:0]        restore_id;
        logic [WORD_W-1:0]  restore_value;
        logic               last;
        logic               end_reached;
        logic [COUNT_W-1:0] entry_count;
    } t_restore;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic in_valid = 1'b0;
    logic [1:0] command = CMD_RECORD;
    logic [KIND_W-1:0] change_kind = KIND_UNMARKED;
    logic signed [31:0] target_id = '0;
    logic [WORD_W-1:0] old_value = '0;
    logic [WORD_W-1:0] new_value = '0;
    logic out_stall = 1'b0;

    wire logic                in_stall;
    wire logic                out_valid;
    wire logic                has_value;
    wire logic signed [31:0]  restore_id;
    wire logic [WORD_W-1:0]   restore_value;
    wire logic                last;
    wire logic                end_reached;
    wire logic [COUNT_W-1:0]  entry_count;

    // history model
    bit                rec_on;
    bit [KIND_W-1:0]   kind_mem [DEPTH];
    bit [31:0]         id_mem   [DEPTH];
    bit [WORD_W-1:0]   old_mem  [DEPTH];
    bit [WORD_W-1:0]   new_mem  [DEPTH];
    t_ptr              head_ptr;
    t_ptr              tail_ptr;
    t_ptr              cursor_ptr;

    t_request pending_q [$];
    t_restore restore_q [$];
    t_request req;
    t_restore seen;
    t_restore want;

    bit idling = 1'b1;
    int n_queued;
    int n_taken;
    int n_errors;
    int send_gap;
    int stall_left;
    int hold_left;
    bit hold_done;
    int quiet_cycles;

    undo_redo_trace_history #(
        .DEPTH_LOG2(DEPTH_LOG2)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_command      (command),
        .i_change_kind  (change_kind),
        .i_target_id    (target_id),
        .i_old_value    (old_value),
        .i_new_value    (new_value),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_has_value    (has_value),
        .o_restore_id   (restore_id),
        .o_restore_value(restore_value),
        .o_last         (last),
        .o_end_reached  (end_reached),
        .o_entry_count  (entry_count)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic void expect_restore(bit has, logic [31:0] id, logic [WORD_W-1:0] val,
                                           bit fin, bit boundary);
        t_restore r;
        t_ptr held;
        held = head_ptr - tail_ptr;
        r.has_value     = has;
        r.restore_id    = id;
        r.restore_value = val;
        r.last          = fin;
        r.end_reached   = boundary;
        r.entry_count   = held;
        restore_q.push_back(r);
    endfunction

    task automatic advance_history(input logic [1:0] cmd, input logic [KIND_W-1:0] kind,
                                   input logic [31:0] id, input logic [WORD_W-1:0] oldv,
                                   input logic [WORD_W-1:0] newv);
        t_ptr idx;
        t_ptr held;
        logic [WORD_W-1:0] val;
        bit grp;
        bit done;
        case (cmd)
            CMD_RECORD: begin
                if (rec_on && (oldv != newv || kind != KIND_UNMARKED)) begin
                    // anything past the cursor is redo history and goes away
                    head_ptr = cursor_ptr;
                    held = head_ptr - tail_ptr;
                    if (held == t_ptr'(DEPTH - 1))
                        tail_ptr = tail_ptr + 1'b1;
                    kind_mem[head_ptr] = kind;
                    id_mem[head_ptr]   = id;
                    old_mem[head_ptr]  = oldv;
                    new_mem[head_ptr]  = newv;
                    head_ptr   = head_ptr + 1'b1;
                    cursor_ptr = head_ptr;
                end
            end
            CMD_WIPE: begin
                head_ptr   = '0;
                tail_ptr   = '0;
                cursor_ptr = '0;
            end
            default: begin
                done = 1'b0;
                while (!done) begin
                    if ((cmd == CMD_UNDO && cursor_ptr == tail_ptr) ||
                        (cmd == CMD_REDO && cursor_ptr == head_ptr)) begin
                        expect_restore(1'b0, '0, '0, 1'b1, 1'b1);
                        done = 1'b1;
                    end else begin
                        if (cmd == CMD_UNDO) begin
                            cursor_ptr = cursor_ptr - 1'b1;
                            idx = cursor_ptr;
                            val = old_mem[idx];
                        end else begin
                            idx = cursor_ptr;
                            val = new_mem[idx];
                            cursor_ptr = cursor_ptr + 1'b1;
                        end
                        grp = kind_mem[idx] >= KIND_GROUP;
                        expect_restore(1'b1, id_mem[idx], val, grp, 1'b0);
                        done = grp;
                    end
                end
            end
        endcase
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                advance_history(command, change_kind, target_id, old_value, new_value);
                n_taken <= n_taken + 1;
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    req = pending_q.pop_front();
                    command     <= req.cmd;
                    change_kind <= req.kind;
                    target_id   <= req.id;
                    old_value   <= req.old_val;
                    new_value   <= req.new_val;
                    in_valid    <= 1'b1;
                    if (idling && $urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 3);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            seen = {has_value, restore_id, restore_value, last, end_reached, entry_count};
            if (restore_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result: has=%0b id=%h val=%h last=%0b end=%0b count=%0d",
                             seen.has_value, seen.restore_id, seen.restore_value, seen.last,
                             seen.end_reached, seen.entry_count);
            end else begin
                want = restore_q.pop_front();
                if (seen !== want) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $write("result mismatch: exp has=%0b id=%h val=%h last=%0b end=%0b count=%0d",
                               want.has_value, want.restore_id, want.restore_value, want.last,
                               want.end_reached, want.entry_count);
                        $display(" / got has=%0b id=%h val=%h last=%0b end=%0b count=%0d",
                                 seen.has_value, seen.restore_id, seen.restore_value, seen.last,
                                 seen.end_reached, seen.entry_count);
                    end
                end
            end
        end
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (!hold_done && n_taken >= HOLD_AT) begin
            // long hold-off so the block backs up into its request side
            hold_done = 1'b1;
            hold_left = HOLD_LEN - 1;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic void queue_item(logic [1:0] cmd, logic [KIND_W-1:0] kind,
                                       logic [31:0] id, logic [WORD_W-1:0] oldv,
                                       logic [WORD_W-1:0] newv);
        t_request r;
        r = '{cmd, kind, id, oldv, newv};
        pending_q.push_back(r);
        n_queued++;
    endfunction

    // undo/redo requests carry junk in the fields they do not use
    function automatic void queue_run(logic [1:0] cmd);
        queue_item(cmd, KIND_W'($urandom), $urandom, $urandom, $urandom);
    endfunction

    function automatic logic [WORD_W-1:0] pick_new(logic [WORD_W-1:0] oldv);
        return ($urandom_range(0, 7) == 0) ? oldv : WORD_W'($urandom);
    endfunction

    // one instruction group of changes, often followed by undo/redo
    function automatic void add_group();
        int nrec;
        int tail_pick;
        logic [WORD_W-1:0] ov;
        logic [KIND_W-1:0] kd;
        nrec = $urandom_range(1, 5);
        for (int k = 0; k < nrec; k++) begin
            ov = $urandom;
            kd = (k == 0) ? KIND_W'($urandom_range(KIND_GROUP, KIND_GROUP_ALT))
                          : KIND_W'($urandom_range(KIND_UNMARKED, KIND_OPCODE));
            queue_item(CMD_RECORD, kd, $urandom, ov, pick_new(ov));
        end
        tail_pick = $urandom_range(0, 9);
        if (tail_pick >= 3 && tail_pick <= 8)
            queue_run(CMD_UNDO);
        if (tail_pick == 6 || tail_pick == 7 || tail_pick == 9)
            queue_run(CMD_REDO);
        if (tail_pick == 8)
            queue_run(CMD_UNDO);
    endfunction

    function automatic void add_random(int n);
        int stop_at;
        logic [WORD_W-1:0] ov;
        stop_at = n_queued + n;
        while (n_queued < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                add_group();
            end else begin
                ov = $urandom;
                queue_item(2'($urandom), KIND_W'($urandom), $urandom, ov, pick_new(ov));
            end
        end
    endfunction

    task automatic wait_quiet();
        while (pending_q.size() != 0 || in_valid || restore_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_recording(bit on);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        rec_on = on;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [WORD_W-1:0] ov;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        set_recording(1'b0);
        queue_item(CMD_RECORD, KIND_OPCODE, 32'd4, 32'd1, 32'd2);
        queue_run(CMD_UNDO);
        queue_run(CMD_REDO);

        set_recording(1'b1);
        // unchanged and unmarked: dropped
        queue_item(CMD_RECORD, KIND_UNMARKED, 32'd9, 32'h5, 32'h5);
        queue_item(CMD_RECORD, KIND_GROUP, 32'h7fffffff, 32'h0, 32'hffffffff);
        queue_item(CMD_RECORD, KIND_UNMARKED, 32'h80000000, 32'hffffffff, 32'h0);
        // marked, so kept even though unchanged
        queue_item(CMD_RECORD, KIND_OPCODE, 32'hffffffff, 32'h12345678, 32'h12345678);
        queue_item(CMD_RECORD, KIND_UNMARKED, 32'h0, 32'h1, 32'h2);
        queue_item(CMD_RECORD, KIND_GROUP_ALT, 32'd100, 32'haaaaaaaa, 32'h55555555);
        queue_item(CMD_RECORD, KIND_UNMARKED, 32'hfffffffe, 32'h55555555, 32'haaaaaaaa);
        queue_run(CMD_UNDO);
        queue_run(CMD_UNDO);
        queue_run(CMD_UNDO);
        queue_run(CMD_REDO);
        queue_run(CMD_REDO);
        queue_run(CMD_UNDO);
        queue_item(CMD_RECORD, KIND_UNMARKED, 32'd7, 32'h0, 32'h1);
        queue_run(CMD_REDO);
        queue_item(CMD_WIPE, 2'b11, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        queue_run(CMD_UNDO);
        queue_run(CMD_REDO);

        add_random(30);
        // overfill the ring so the oldest records get dropped, then walk it end to end
        for (int k = 0; k < DEPTH + 2; k++) begin
            ov = $urandom;
            queue_item(CMD_RECORD, KIND_W'($urandom_range(KIND_UNMARKED, KIND_OPCODE)),
                       $urandom, ov, ~ov);
        end
        queue_run(CMD_UNDO);
        queue_run(CMD_REDO);
        queue_run(CMD_UNDO);
        add_random(20);

        set_recording(1'b0);
        add_random(15);

        set_recording(1'b1);
        idling = 1'b0;
        add_random(25);

        set_recording(1'b0);
        idling = 1'b1;
        add_random(10);

        set_recording(1'b1);
        idling = 1'b0;
        add_random(15);

        wait_quiet();
        if (n_errors == 0 && restore_q.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
